FILE: rtl/core/tx16fe_pkg.sv
// Package: constants, codes and types shared by the transmit-request frame encoder.
`default_nettype none

package tx16fe_pkg;

    // Fixed frame bytes
    localparam logic [7:0] START_DELIM = 8'h7E;
    localparam logic [7:0] LEN_HIGH    = 8'h00;
    localparam logic [7:0] API_ID_TX16 = 8'h01;
    localparam logic [7:0] FRAME_ID    = 8'h01;
    localparam logic [7:0] OPTIONS     = 8'h00;
    localparam logic [7:0] LEN_EXTRA   = 8'd5;
    localparam logic [7:0] MAX_PAYLOAD = 8'd250;
    localparam logic [7:0] MIN_PAYLOAD = 8'd1;

    // Command codes carried on the input tuser
    localparam logic CMD_BEGIN = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    // Output step codes within one item
    localparam int unsigned STEP_W = 3;
    localparam logic [STEP_W-1:0] HDR_DELIM   = 3'd0;
    localparam logic [STEP_W-1:0] HDR_LEN_HI  = 3'd1;
    localparam logic [STEP_W-1:0] HDR_LEN_LO  = 3'd2;
    localparam logic [STEP_W-1:0] HDR_API_ID  = 3'd3;
    localparam logic [STEP_W-1:0] HDR_FRM_ID  = 3'd4;
    localparam logic [STEP_W-1:0] HDR_ADDR_HI = 3'd5;
    localparam logic [STEP_W-1:0] HDR_ADDR_LO = 3'd6;
    localparam logic [STEP_W-1:0] HDR_OPTIONS = 3'd7;
    localparam logic [STEP_W-1:0] STEP_DATA   = 3'd0;
    localparam logic [STEP_W-1:0] STEP_CSUM   = 3'd1;

    typedef struct packed {
        logic        cmd;
        logic [15:0] dest_addr;
        logic [7:0]  payload_len;
        logic [7:0]  data_byte;
    } t_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
        logic       error;
        logic       abandoned;
    } t_result;

    typedef struct packed {
        logic       frame_open;
        logic [7:0] bytes_left;
        logic [7:0] sum_acc;
    } t_frame_state;

endpackage

`default_nettype wire

FILE: rtl/core/tx16fe_byte_sel.sv
// Byte selector: picks the frame byte for one step of an item and the next frame state.
`default_nettype none

module tx16fe_byte_sel (
    input  tx16fe_pkg::t_item                i_item,
    input  logic [tx16fe_pkg::STEP_W-1:0]    i_step,
    input  tx16fe_pkg::t_frame_state         i_state,
    output tx16fe_pkg::t_result              o_result,
    output logic                             o_last,
    output tx16fe_pkg::t_frame_state         o_state
);
    import tx16fe_pkg::*;

    logic [7:0] len_clamped;
    logic [7:0] sum_next;

    always_comb begin
        if (i_item.payload_len < MIN_PAYLOAD) begin
            len_clamped = MIN_PAYLOAD;
        end else if (i_item.payload_len > MAX_PAYLOAD) begin
            len_clamped = MAX_PAYLOAD;
        end else begin
            len_clamped = i_item.payload_len;
        end
    end

    assign sum_next = i_state.sum_acc + i_item.data_byte;

    always_comb begin
        o_result = '0;
        o_last   = 1'b0;
        o_state  = i_state;
        if (i_item.cmd == CMD_BEGIN) begin
            o_last = (i_step == HDR_OPTIONS);
            case (i_step)
                HDR_DELIM: begin
                    o_result.out_byte  = START_DELIM;
                    o_result.abandoned = i_state.frame_open;
                    // The whole header is known at once, so the state moves here.
                    o_state.frame_open = 1'b1;
                    o_state.bytes_left = len_clamped;
                    o_state.sum_acc    = API_ID_TX16 + FRAME_ID + OPTIONS
                                         + i_item.dest_addr[15:8] + i_item.dest_addr[7:0];
                end
                HDR_LEN_HI:  o_result.out_byte = LEN_HIGH;
                HDR_LEN_LO:  o_result.out_byte = len_clamped + LEN_EXTRA;
                HDR_API_ID:  o_result.out_byte = API_ID_TX16;
                HDR_FRM_ID:  o_result.out_byte = FRAME_ID;
                HDR_ADDR_HI: o_result.out_byte = i_item.dest_addr[15:8];
                HDR_ADDR_LO: o_result.out_byte = i_item.dest_addr[7:0];
                HDR_OPTIONS: o_result.out_byte = OPTIONS;
                default:     o_result.out_byte = OPTIONS;
            endcase
        end else if (!i_state.frame_open) begin
            o_result.error = 1'b1;
            o_last         = 1'b1;
        end else begin
            case (i_step)
                STEP_DATA: begin
                    o_result.out_byte  = i_item.data_byte;
                    o_state.sum_acc    = sum_next;
                    o_state.bytes_left = i_state.bytes_left - 8'd1;
                    o_last             = (i_state.bytes_left != 8'd1);
                end
                STEP_CSUM: begin
                    // The frame stays open with no bytes left until its checksum goes out.
                    o_result.out_byte  = ~i_state.sum_acc;
                    o_result.frame_end = 1'b1;
                    o_last             = 1'b1;
                    o_state.frame_open = 1'b0;
                    o_state.sum_acc    = '0;
                end
                default: begin
                    o_last = 1'b1;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/tx16_api_frame_encoder.sv
// Top level of the 16-bit address transmit-request frame encoder.
//
// The encoder turns a stream of command items into the bytes of radio-modem API
// transmit frames. A begin item (s_axis_tuser = 0) carries the destination address
// and the payload length; it produces eight header bytes: the start delimiter 0x7E,
// the length high byte 0x00, the length low byte (payload count plus five), the API
// id 0x01, the frame id 0x01, the address high and low bytes and the options byte
// 0x00. A payload count of zero is sent as one and a count above 250 as 250. Each
// data item (s_axis_tuser = 1) produces its own byte, and the item carrying the last
// announced payload byte also produces the checksum byte, 0xFF minus the low eight
// bits of the sum from the API id onward, flagged with m_axis_tlast. A data item with
// no frame open produces a single zero byte with the error flag set, and a begin that
// cuts off an open frame flags its delimiter byte as abandoned. The output port
// delivers one byte per cycle while not stalled, so a begin item occupies the block
// for its eight header bytes, a closing data item for two bytes and any other data
// item for one; a following item is taken in the same cycle as the last byte of the
// current one is registered, so data bytes stream at one item per clock unless the output is stalled. An input item
// register feeds a byte selector, whose result lands in the output register; that
// register holds its byte steady while the downstream side stalls, and the item in
// hand waits until the byte has been taken. Reset is synchronous and active low.
`default_nettype none

module tx16_api_frame_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // [15:0] dest_addr, [23:16] payload_len, [31:24] data_byte
    input  logic        s_axis_tuser,  // [0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // [7:0] out_byte
    output logic        m_axis_tlast,
    output logic [1:0]  m_axis_tuser   // [0] error, [1] abandoned
);
    import tx16fe_pkg::*;

    // Item register: the command currently being turned into bytes.
    t_item              r_item;
    logic               r_item_valid;
    logic [STEP_W-1:0]  r_step;
    logic [STEP_W-1:0]  n_step;
    t_frame_state       r_state;

    // Output register.
    t_result            r_out;
    logic               r_out_valid;

    t_result            sel_result;
    t_frame_state       sel_state;
    logic               sel_last;
    logic               out_free;
    logic               fire;
    logic               in_accept;
    t_item              in_item;

    tx16fe_byte_sel u_byte_sel (
        .i_item   (r_item),
        .i_step   (r_step),
        .i_state  (r_state),
        .o_result (sel_result),
        .o_last   (sel_last),
        .o_state  (sel_state)
    );

    // A byte can be produced whenever the output register is empty or being drained.
    assign out_free      = !r_out_valid || m_axis_tready;
    assign fire          = r_item_valid && out_free;
    assign s_axis_tready = !r_item_valid || (fire && sel_last);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign n_step = sel_last ? HDR_DELIM : r_step + 3'd1;

    always_comb begin
        in_item.cmd         = s_axis_tuser;
        in_item.dest_addr   = s_axis_tdata[15:0];
        in_item.payload_len = s_axis_tdata[23:16];
        in_item.data_byte   = s_axis_tdata[31:24];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
            r_step       <= HDR_DELIM;
            r_state      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (in_accept) begin
                r_item_valid <= 1'b1;
            end else if (fire && sel_last) begin
                r_item_valid <= 1'b0;
            end
            if (fire) begin
                r_step      <= n_step;
                r_state     <= sel_state;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item <= in_item;
        end
        if (fire) begin
            r_out <= sel_result;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out.out_byte;
    assign m_axis_tlast    = r_out.frame_end;
    assign m_axis_tuser[0] = r_out.error;
    assign m_axis_tuser[1] = r_out.abandoned;

endmodule

`default_nettype wire

FILE: rtl/core/tx16fe_checker.sv
// Checker: port-level properties of the frame encoder, bound to the top level.
`default_nettype none

module tx16fe_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [31:0] s_axis_tdata,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tlast,
    input logic [1:0]  m_axis_tuser
);

    // Output register is empty straight after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // A stalled output byte holds with its flags.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("stalled output changed");

    // An error byte is zero and never closes a frame.
    a_error_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            m_axis_tdata == 8'h00 && !m_axis_tlast && !m_axis_tuser[1])
        else $error("malformed error byte");

    // Abandon is flagged only on a start delimiter.
    a_abandon_delim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == 8'h7E && !m_axis_tlast)
        else $error("abandon flag off the delimiter");

    // An accepted input item carries no unknown bits.
    a_input_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |-> !$isunknown({s_axis_tuser, s_axis_tdata}))
        else $error("unknown input item accepted");

endmodule

bind tx16_api_frame_encoder tx16fe_checker u_tx16fe_checker (.*);

`default_nettype wire

FILE: dv/tx16_api_frame_encoder_tb.sv
// Self-checking testbench for the 16-bit address transmit-request frame encoder.
`timescale 1ns / 100ps

module tx16_api_frame_encoder_tb;

    import tx16fe_pkg::*;

    // The checksum is this value minus the low byte of the running sum.
    localparam logic [7:0] CSUM_BASE = 8'hFF;
    // Run length of the random part, counted in input items.
    localparam int RAND_ITEMS = 256;
    // Cycles allowed after the last expected byte for stray output to show up.
    localparam int SETTLE_CYCLES = 20;

    // One queued command item, with a flag that makes the sender wait until
    // every byte already predicted has left the block before offering it.
    typedef struct packed {
        logic  hold_drain;
        t_item item;
    } t_tx_cmd;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;  // [15:0] dest_addr, [23:16] payload_len, [31:24] data_byte
    logic        s_axis_tuser  = CMD_BEGIN;  // [0] cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;   // [7:0] out_byte
    logic        m_axis_tlast;
    logic [1:0]  m_axis_tuser;   // [0] error, [1] abandoned

    t_tx_cmd      cmd_q[$];      // command items still to be offered
    t_result      frame_bytes_q[$];  // frame bytes predicted but not yet seen
    t_frame_state enc_st;        // predicted frame state of the encoder
    int           n_bad;
    logic         took_item = 1'b0;  // an input item was accepted at the last edge

    // Idle control for both sides.
    int           tx_gap  = 0;
    int           rx_hold = 0;
    bit           tx_calm = 1'b0;
    bit           rx_calm = 1'b0;

    tx16_api_frame_encoder i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // The encoder sends a length of zero as one and saturates long lengths at
    // the largest payload a frame may carry.
    function automatic logic [7:0] clamp_len(input logic [7:0] n);
        if (n < MIN_PAYLOAD) begin
            return MIN_PAYLOAD;
        end
        if (n > MAX_PAYLOAD) begin
            return MAX_PAYLOAD;
        end
        return n;
    endfunction

    // Gap lengths: drawn mostly from the shortest range, sometimes from a middle range, rarely a long pause.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(1, 2);
        end else if (r < 92) begin
            return $urandom_range(3, 6);
        end
        return $urandom_range(10, 40);
    endfunction

    // Works out the bytes that one accepted command item makes the encoder send,
    // and advances the predicted frame state.
    task automatic predict_frame_bytes(input t_item it);
        logic [7:0] hi;
        logic [7:0] lo;
        logic [7:0] n;
        t_result    r;
        if (it.cmd == CMD_BEGIN) begin
            hi = it.dest_addr[15:8];
            lo = it.dest_addr[7:0];
            n  = clamp_len(it.payload_len);
            // Only the delimiter carries the abandoned flag, and only when a
            // frame was still open.
            r = '{out_byte: START_DELIM, frame_end: 1'b0, error: 1'b0,
                  abandoned: enc_st.frame_open};
            frame_bytes_q.push_back(r);
            r.abandoned = 1'b0;
            r.out_byte  = LEN_HIGH;
            frame_bytes_q.push_back(r);
            r.out_byte  = n + LEN_EXTRA;
            frame_bytes_q.push_back(r);
            r.out_byte  = API_ID_TX16;
            frame_bytes_q.push_back(r);
            r.out_byte  = FRAME_ID;
            frame_bytes_q.push_back(r);
            r.out_byte  = hi;
            frame_bytes_q.push_back(r);
            r.out_byte  = lo;
            frame_bytes_q.push_back(r);
            r.out_byte  = OPTIONS;
            frame_bytes_q.push_back(r);
            // The checksum covers everything from the API id onward.
            enc_st.sum_acc    = API_ID_TX16 + FRAME_ID + hi + lo + OPTIONS;
            enc_st.bytes_left = n;
            enc_st.frame_open = 1'b1;
        end else if (!enc_st.frame_open) begin
            // A payload byte outside a frame yields a lone zero byte with the
            // error flag, and leaves the state as it was.
            r = '{out_byte: 8'h00, frame_end: 1'b0, error: 1'b1, abandoned: 1'b0};
            frame_bytes_q.push_back(r);
        end else begin
            r = '{out_byte: it.data_byte, frame_end: 1'b0, error: 1'b0, abandoned: 1'b0};
            frame_bytes_q.push_back(r);
            enc_st.sum_acc    = enc_st.sum_acc + it.data_byte;
            enc_st.bytes_left = enc_st.bytes_left - 8'd1;
            if (enc_st.bytes_left == 8'd0) begin
                r.out_byte  = CSUM_BASE - enc_st.sum_acc;
                r.frame_end = 1'b1;
                frame_bytes_q.push_back(r);
                enc_st.frame_open = 1'b0;
                enc_st.sum_acc    = 8'h00;
            end
        end
    endtask

    task automatic queue_item(input logic cmd, input logic [15:0] addr,
                              input logic [7:0] len, input logic [7:0] dat,
                              input bit drain);
        t_tx_cmd c;
        c.hold_drain       = drain;
        c.item.cmd         = cmd;
        c.item.dest_addr   = addr;
        c.item.payload_len = len;
        c.item.data_byte   = dat;
        cmd_q.push_back(c);
    endtask

    // The fields that an item does not use are filled with random values, since
    // the encoder must ignore them.
    task automatic queue_begin(input logic [15:0] addr, input logic [7:0] len,
                               input bit drain);
        queue_item(CMD_BEGIN, addr, len, 8'($urandom), drain);
    endtask

    task automatic queue_payload(input logic [7:0] dat);
        queue_item(CMD_DATA, 16'($urandom), 8'($urandom), dat, 1'b0);
    endtask

    // Sender. A new item is offered only once the previous one has been taken
    // and any gap has run out.
    always @(negedge i_clk) begin : sender
        t_tx_cmd c;
        if (i_rst_n && !(s_axis_tvalid && !took_item)) begin
            if ($urandom_range(0, 99) == 0) begin
                tx_calm = !tx_calm;
            end
            if (tx_gap > 0) begin
                tx_gap        = tx_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (cmd_q.size() != 0 &&
                         !(cmd_q[0].hold_drain && frame_bytes_q.size() != 0)) begin
                c = cmd_q.pop_front();
                s_axis_tdata  <= {c.item.data_byte, c.item.payload_len, c.item.dest_addr};
                s_axis_tuser  <= c.item.cmd;
                s_axis_tvalid <= 1'b1;
                if (!tx_calm && $urandom_range(0, 2) == 0) begin
                    tx_gap = pick_gap();
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure, with calm stretches where it never stalls.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if ($urandom_range(0, 99) == 0) begin
                rx_calm = !rx_calm;
            end
            if (rx_hold > 0) begin
                rx_hold       = rx_hold - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (!rx_calm && $urandom_range(0, 3) == 0) begin
                    rx_hold = pick_gap();
                end
            end
        end
    end

    // Monitor. Accepted command items are predicted at the edge that takes
    // them; accepted output bytes are checked against the oldest prediction.
    always @(posedge i_clk) begin : monitor
        t_item   it;
        t_result got;
        t_result want;
        took_item <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                it.cmd         = s_axis_tuser;
                it.dest_addr   = s_axis_tdata[15:0];
                it.payload_len = s_axis_tdata[23:16];
                it.data_byte   = s_axis_tdata[31:24];
                predict_frame_bytes(it);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.out_byte  = m_axis_tdata;
                got.frame_end = m_axis_tlast;
                got.error     = m_axis_tuser[0];
                got.abandoned = m_axis_tuser[1];
                if (frame_bytes_q.size() == 0) begin
                    n_bad = n_bad + 1;
                    if (n_bad <= 10) begin
                        $display("%0t: unexpected byte %h last %b error %b abandoned %b",
                                 $realtime, got.out_byte, got.frame_end, got.error,
                                 got.abandoned);
                    end
                end else begin
                    want = frame_bytes_q.pop_front();
                    if (got.out_byte !== want.out_byte || got.frame_end !== want.frame_end ||
                        got.error !== want.error || got.abandoned !== want.abandoned) begin
                        n_bad = n_bad + 1;
                        if (n_bad <= 10) begin
                            $display("%0t: byte mismatch: expected %h/%b/%b/%b, got %h/%b/%b/%b",
                                     $realtime, want.out_byte, want.frame_end, want.error,
                                     want.abandoned, got.out_byte, got.frame_end, got.error,
                                     got.abandoned);
                        end
                    end
                end
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        int         n_rand;
        int         pick;
        int         sel;
        int         cut;
        int         k;
        logic [7:0] len;
        bit         first_rand;

        n_bad        = 0;
        enc_st       = '0;
        n_rand       = 0;
        first_rand   = 1'b1;

        // Directed part. A payload byte straight after reset has no frame.
        queue_payload(8'hA5);
        // Zero length is sent as one payload byte; lowest address.
        queue_begin(16'h0000, 8'd0, 1'b0);
        queue_payload(8'h00);
        // Stray payload byte after a closed frame.
        queue_payload(8'hFF);
        // Highest length saturates; the frame is then cut off by a new begin.
        queue_begin(16'hFFFF, 8'd255, 1'b0);
        queue_payload(8'hFF);
        queue_payload(8'h80);
        queue_begin(16'h1234, 8'd1, 1'b0);
        queue_payload(8'hFF);
        // Largest legal length, abandoned, then two begins in a row.
        queue_begin(16'h8001, 8'd250, 1'b0);
        queue_payload(8'h01);
        queue_payload(8'h7E);
        queue_begin(16'h5AA5, 8'd251, 1'b0);
        queue_begin(16'hA55A, 8'd3, 1'b0);
        queue_payload(8'h00);
        queue_payload(8'hFF);
        queue_payload(8'h55);
        queue_begin(16'h00FF, 8'd2, 1'b0);
        queue_payload(8'hFE);
        queue_payload(8'hFF);
        // Left open so that the random part starts by abandoning it.
        queue_begin(16'hFF00, 8'd128, 1'b0);
        queue_payload(8'h7F);

        // Random part: mostly complete frames with random content, the rest
        // frames cut short and stray payload bytes.
        while (n_rand < RAND_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 72 || first_rand) begin
                sel = $urandom_range(0, 99);
                if (sel < 70) begin
                    len = 8'($urandom_range(1, 6));
                end else if (sel < 93) begin
                    len = 8'($urandom_range(7, 24));
                end else begin
                    len = 8'd0;
                end
                // Now and then the sender waits for the block to empty first.
                queue_begin(16'($urandom), len, first_rand || $urandom_range(0, 11) == 0);
                for (k = 0; k < clamp_len(len); k++) begin
                    queue_payload(8'($urandom));
                end
                n_rand = n_rand + clamp_len(len) + 1;
            end else if (pick < 88) begin
                // Any length at all, since the frame never reaches its end.
                len = 8'($urandom);
                cut = $urandom_range(0, (clamp_len(len) > 6) ? 5 : clamp_len(len) - 1);
                queue_begin(16'($urandom), len, 1'b0);
                for (k = 0; k < cut; k++) begin
                    queue_payload(8'($urandom));
                end
                n_rand = n_rand + cut + 1;
            end else begin
                cut = $urandom_range(1, 3);
                for (k = 0; k < cut; k++) begin
                    queue_payload(8'($urandom));
                end
                n_rand = n_rand + cut;
            end
            first_rand = 1'b0;
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every item to be taken and every predicted byte to arrive,
        // then give the block time to show any byte it should not send.
        while (cmd_q.size() != 0 || s_axis_tvalid || frame_bytes_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        if (n_bad == 0) begin
            $display("tx16_api_frame_encoder regression: pass");
        end else begin
            $display("tx16_api_frame_encoder regression: fail");
        end
        $finish;
    end

    // Watchdog, several times the slowest correct run.
    initial begin
        #5000000;
        $display("tx16_api_frame_encoder regression: fail");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/tx16fe_pkg.sv
rtl/core/tx16fe_byte_sel.sv
rtl/core/tx16_api_frame_encoder.sv
rtl/core/tx16fe_checker.sv
dv/tx16_api_frame_encoder_tb.sv
